// ===== rtl/pf_pkg.sv =====
`timescale 1ns / 1ps

package pf_pkg;

    // letter code, one square cell
    typedef logic [4:0] pf_code_t;
    typedef pf_code_t [24:0] pf_square_t;

    // configuration register indexes
    localparam logic [1:0] REG_MODE        = 2'd0;
    localparam logic [1:0] REG_CELLS_LOW   = 2'd1;
    localparam logic [1:0] REG_CELLS_MID   = 2'd2;
    localparam logic [1:0] REG_CELLS_HIGH  = 2'd3;

    localparam int CFG_DATA_W = 50;

    // reset square: A B C D E / F G H I K / L M N O P / Q R S T U / V W X Y Z
    localparam logic [49:0] CELLS_LOW_RST  = 50'd360886946596896;
    localparam logic [49:0] CELLS_MID_RST  = 50'd725215444678027;
    localparam logic [24:0] CELLS_HIGH_RST = 25'd27025109;

    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_I     = 8'h49;
    localparam logic [7:0] CHAR_J     = 8'h4a;
    localparam logic [7:0] CHAR_X     = 8'h58;
    localparam logic [7:0] CHAR_Z     = 8'h5a;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z = 8'h7a;
    localparam logic [7:0] CASE_GAP   = 8'h20;

    typedef struct packed {
        logic       decrypt;
        pf_square_t square;
    } pf_cfg_t;

    // one raw pair waiting for the cipher lane
    typedef struct packed {
        logic [7:0] sym_a;
        logic [7:0] sym_b;
        logic       decrypt;
        logic       odd_tail;
        logic       last;
    } pf_pair_t;

    // handshake from prep buffer to cipher lane
    typedef struct packed {
        logic     valid;
        pf_pair_t pair;
    } pf_pair_beat_t;

    typedef struct packed {
        logic       found;
        logic [2:0] row;
        logic [2:0] col;
    } pf_pos_t;

    // position of the first cell holding the symbol, row-major
    function automatic pf_pos_t pf_locate(input pf_square_t sq, input logic [7:0] sym);
        pf_pos_t  pos;
        pf_code_t code;
        pos  = '0;
        code = pf_code_t'(sym - CHAR_A);
        if (sym >= CHAR_A && sym <= CHAR_Z) begin
            for (int k = 24; k >= 0; k--) begin
                if (sq[k] == code) begin
                    pos.found = 1'b1;
                    pos.row   = 3'(k / 5);
                    pos.col   = 3'(k % 5);
                end
            end
        end
        return pos;
    endfunction

    // move one place along a row or column, wrapping at five
    function automatic logic [2:0] pf_shift(input logic [2:0] v, input logic decrypt);
        logic [2:0] r;
        if (decrypt)
            r = (v == 3'd0) ? 3'd4 : v - 3'd1;
        else
            r = (v == 3'd4) ? 3'd0 : v + 3'd1;
        return r;
    endfunction

    function automatic logic [7:0] pf_cell_byte(input pf_square_t sq, input logic [2:0] row,
                                                input logic [2:0] col);
        logic [4:0] idx;
        idx = {2'b00, row} * 5'd5 + {2'b00, col};
        return CHAR_A + {3'b000, sq[idx]};
    endfunction

endpackage

// ===== rtl/pf_if.sv =====
`timescale 1ns / 1ps

// message byte channel
interface pf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_message;

    modport source (output valid, output char_code, output end_of_message, input ready);
    modport sink   (input valid, input char_code, input end_of_message, output ready);
endinterface

// cipher pair channel
interface pf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] first_letter;
    logic [7:0] second_letter;
    logic       last_pair;
    logic       bad_symbol;

    modport source (output valid, output first_letter, output second_letter,
                    output last_pair, output bad_symbol, input ready);
    modport sink   (input valid, input first_letter, input second_letter,
                    input last_pair, input bad_symbol, output ready);
endinterface

// configuration write channel
interface pf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [49:0] write_data;

    modport source (output valid, output reg_index, output write_data, input ready);
    modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

// ===== rtl/pf_cfg_regs.sv =====
`timescale 1ns / 1ps

module pf_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    pf_cfg_if.sink          cfg,
    output pf_pkg::pf_cfg_t cfg_state
);
    import pf_pkg::*;

    logic        mode_reg;
    logic [49:0] low_reg;
    logic [49:0] mid_reg;
    logic [24:0] high_reg;

    assign cfg.ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            low_reg  <= CELLS_LOW_RST;
            mid_reg  <= CELLS_MID_RST;
            high_reg <= CELLS_HIGH_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                REG_MODE:       mode_reg <= cfg.write_data[0];
                REG_CELLS_LOW:  low_reg  <= cfg.write_data;
                REG_CELLS_MID:  mid_reg  <= cfg.write_data;
                REG_CELLS_HIGH: high_reg <= cfg.write_data[24:0];
            endcase
        end
    end

    assign cfg_state.decrypt = mode_reg;
    assign cfg_state.square  = pf_square_t'({high_reg, mid_reg, low_reg});

endmodule

// ===== rtl/pf_prep.sv =====
`timescale 1ns / 1ps

module pf_prep (
    input  logic                  clk,
    input  logic                  rst_n,
    pf_in_if.sink                 msg_in,
    input  logic                  decrypt,
    output pf_pkg::pf_pair_beat_t pair_beat,
    input  logic                  pair_pop
);
    import pf_pkg::*;

    logic [7:0] held_reg, held_next;
    logic       held_valid_reg, held_valid_next;
    logic [7:0] prev_reg, prev_next;
    logic       prev_valid_reg, prev_valid_next;

    pf_pair_t   slot_reg [2];
    logic [1:0] cnt_reg;

    pf_pair_t   gen [2];
    logic [1:0] gen_cnt;
    logic [7:0] sym [2];
    logic [1:0] sym_cnt;
    logic [7:0] up;
    logic       is_letter;
    logic       accept;
    logic       pop;

    // take a new byte when the buffer is empty or drains to empty this cycle
    assign pop          = pair_pop && (cnt_reg != 2'd0);
    assign msg_in.ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);
    assign accept       = msg_in.valid && msg_in.ready;

    // text preparation and pairing
    always_comb
    begin
        up        = msg_in.char_code;
        is_letter = 1'b0;
        sym[0]    = '0;
        sym[1]    = '0;
        sym_cnt   = 2'd0;
        gen[0]    = '0;
        gen[1]    = '0;
        gen_cnt   = 2'd0;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;

        if (msg_in.char_code >= CHAR_LOW_A && msg_in.char_code <= CHAR_LOW_Z)
            up = msg_in.char_code - CASE_GAP;
        is_letter = (up >= CHAR_A && up <= CHAR_Z);
        if (up == CHAR_J)
            up = CHAR_I;

        if (decrypt)
        begin
            sym[0]  = msg_in.char_code;
            sym_cnt = 2'd1;
        end
        else if (is_letter)
        begin
            if (prev_valid_reg && prev_reg == up)
            begin
                sym[0]  = CHAR_X;
                sym[1]  = up;
                sym_cnt = 2'd2;
            end
            else
            begin
                sym[0]  = up;
                sym_cnt = 2'd1;
            end
            prev_next       = up;
            prev_valid_next = 1'b1;
        end

        for (int i = 0; i < 2; i++)
        begin
            if (2'(i) < sym_cnt)
            begin
                if (held_valid_next)
                begin
                    gen[gen_cnt[0]].sym_a   = held_next;
                    gen[gen_cnt[0]].sym_b   = sym[i];
                    gen[gen_cnt[0]].decrypt = decrypt;
                    gen_cnt         = gen_cnt + 2'd1;
                    held_valid_next = 1'b0;
                end
                else
                begin
                    held_next       = sym[i];
                    held_valid_next = 1'b1;
                end
            end
        end

        // message end flushes the held symbol
        if (msg_in.end_of_message)
        begin
            if (held_valid_next)
            begin
                gen[gen_cnt[0]].sym_a    = held_next;
                gen[gen_cnt[0]].sym_b    = decrypt ? 8'h00 : CHAR_X;
                gen[gen_cnt[0]].decrypt  = decrypt;
                gen[gen_cnt[0]].odd_tail = decrypt;
                gen_cnt         = gen_cnt + 2'd1;
                held_valid_next = 1'b0;
            end
            prev_valid_next = 1'b0;
            if (gen_cnt != 2'd0)
                gen[gen_cnt[0] - 1'b1].last = 1'b1;
        end
    end

    // symbol state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

    // two-slot pair buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else if (accept)
            cnt_reg <= gen_cnt;
        else if (pop)
            cnt_reg <= cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg[0] <= gen[0];
            slot_reg[1] <= gen[1];
        end
        else if (pop)
            slot_reg[0] <= slot_reg[1];
    end

    assign pair_beat.valid = (cnt_reg != 2'd0);
    assign pair_beat.pair  = slot_reg[0];

endmodule

// ===== rtl/pf_cipher.sv =====
`timescale 1ns / 1ps

module pf_cipher (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pf_pkg::pf_pair_beat_t pair_beat,
    output logic                  pair_pop,
    input  pf_pkg::pf_square_t    square,
    pf_out_if.source              pair_out
);
    import pf_pkg::*;

    pf_pair_t   pair_reg;
    logic       pair_valid_reg;

    logic [7:0] first_reg, first_next;
    logic [7:0] second_reg, second_next;
    logic       last_reg;
    logic       bad_reg, bad_next;
    logic       out_valid_reg;

    pf_pos_t    pos_a;
    pf_pos_t    pos_b;
    logic       out_load;
    logic       stage_ready;

    assign out_load    = !out_valid_reg || pair_out.ready;
    assign stage_ready = !pair_valid_reg || out_load;
    assign pair_pop    = stage_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pair_valid_reg <= 1'b0;
        else if (stage_ready)
            pair_valid_reg <= pair_beat.valid;
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready && pair_beat.valid)
            pair_reg <= pair_beat.pair;
    end

    // row, column and rectangle rules
    always_comb
    begin
        pos_a       = pf_locate(square, pair_reg.sym_a);
        pos_b       = pf_locate(square, pair_reg.sym_b);
        first_next  = pair_reg.sym_a;
        second_next = pair_reg.sym_b;
        bad_next    = 1'b1;
        if (pair_reg.odd_tail)
        begin
            second_next = 8'h00;
        end
        else if (pos_a.found && pos_b.found)
        begin
            bad_next = 1'b0;
            if (pos_a.row == pos_b.row)
            begin
                first_next  = pf_cell_byte(square, pos_a.row,
                                           pf_shift(pos_a.col, pair_reg.decrypt));
                second_next = pf_cell_byte(square, pos_b.row,
                                           pf_shift(pos_b.col, pair_reg.decrypt));
            end
            else if (pos_a.col == pos_b.col)
            begin
                first_next  = pf_cell_byte(square, pf_shift(pos_a.row, pair_reg.decrypt),
                                           pos_a.col);
                second_next = pf_cell_byte(square, pf_shift(pos_b.row, pair_reg.decrypt),
                                           pos_b.col);
            end
            else
            begin
                first_next  = pf_cell_byte(square, pos_a.row, pos_b.col);
                second_next = pf_cell_byte(square, pos_b.row, pos_a.col);
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= pair_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_load && pair_valid_reg)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            last_reg   <= pair_reg.last;
            bad_reg    <= bad_next;
        end
    end

    assign pair_out.valid         = out_valid_reg;
    assign pair_out.first_letter  = first_reg;
    assign pair_out.second_letter = second_reg;
    assign pair_out.last_pair     = last_reg;
    assign pair_out.bad_symbol    = bad_reg;

endmodule

// ===== rtl/playfair_digram_cipher.sv =====
`timescale 1ns / 1ps
// path: the first pair of a byte goes through the pair buffer, the input register and
//   the result register to pair_out; a second pair from the same byte follows behind it
// throughput: one byte per cycle while pair_out is not stalled; a byte with two pairs
//   drops msg_in.ready until one is taken; a two-slot pair buffer feeds one cipher lane
// reset: clears held and previous letters and all valid flags, loads encrypt mode
//   and the alphabetic square; no clearing pass

module playfair_digram_cipher (
    input  logic     clk,
    input  logic     rst_n,
    pf_in_if.sink    msg_in,
    pf_out_if.source pair_out,
    pf_cfg_if.sink   cfg
);
    import pf_pkg::*;

    pf_cfg_t       cfg_state;
    pf_pair_beat_t pair_beat;
    logic          pair_pop;

    pf_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_state (cfg_state)
    );

    pf_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_in    (msg_in),
        .decrypt   (cfg_state.decrypt),
        .pair_beat (pair_beat),
        .pair_pop  (pair_pop)
    );

    pf_cipher u_cipher (
        .clk       (clk),
        .rst_n     (rst_n),
        .pair_beat (pair_beat),
        .pair_pop  (pair_pop),
        .square    (cfg_state.square),
        .pair_out  (pair_out)
    );

endmodule

// ===== rtl/pf_checker.sv =====
`timescale 1ns / 1ps

module pf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] first_letter,
    input logic [7:0] second_letter,
    input logic       last_pair,
    input logic       bad_symbol
);
    import pf_pkg::*;

    // no pair is offered while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("pair offered during reset");

    // a stalled beat keeps its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({first_letter, second_letter, last_pair, bad_symbol}))
        else $error("stalled pair changed");

    // a clean pair is made of square cell bytes
    a_clean_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_symbol |-> first_letter >= CHAR_A && first_letter <= 8'h60
            && second_letter >= CHAR_A && second_letter <= 8'h60)
        else $error("clean pair outside cell byte range");

    // a missing second letter is always flagged
    a_tail_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && second_letter == 8'h00 |-> bad_symbol)
        else $error("empty second letter without error flag");

endmodule

bind playfair_digram_cipher pf_checker u_pf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (pair_out.valid),
    .out_ready     (pair_out.ready),
    .first_letter  (pair_out.first_letter),
    .second_letter (pair_out.second_letter),
    .last_pair     (pair_out.last_pair),
    .bad_symbol    (pair_out.bad_symbol)
);
